>>> rtl/core/slt_pkg.sv
// shared types, codes and character helpers of the small language tokenizer
package slt_pkg;

	localparam int unsigned MAX_WORD_LENGTH = 255;
	localparam int unsigned KEYWORD_LENGTH = 5;

	typedef enum logic [3:0] {
		KIND_TEXT    = 4'd0,
		KIND_EQUALS  = 4'd1,
		KIND_PLUS    = 4'd2,
		KIND_MINUS   = 4'd3,
		KIND_LPAREN  = 4'd4,
		KIND_RPAREN  = 4'd5,
		KIND_LOCAL   = 4'd6,
		KIND_IDENT   = 4'd7,
		KIND_INTEGER = 4'd8,
		KIND_ILLEGAL = 4'd9,
		KIND_EOF     = 4'd10
	} token_kind_t;

	typedef enum logic [2:0] {
		MODE_NONE = 3'b001,
		MODE_WORD = 3'b010,
		MODE_INT  = 3'b100
	} word_mode_t;

	typedef struct packed {
		token_kind_t kind;
		logic [7:0]  ch;
		logic [7:0]  len;
		logic        last;
	} token_t;

	localparam logic [7:0] CHAR_EQUALS = 8'h3d;
	localparam logic [7:0] CHAR_PLUS   = 8'h2b;
	localparam logic [7:0] CHAR_MINUS  = 8'h2d;
	localparam logic [7:0] CHAR_LPAREN = 8'h28;
	localparam logic [7:0] CHAR_RPAREN = 8'h29;

	function automatic logic [7:0] keyword_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h6c;
			3'd1: c = 8'h6f;
			3'd2: c = 8'h63;
			3'd3: c = 8'h61;
			3'd4: c = 8'h6c;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
	endfunction

endpackage

>>> rtl/core/slt_if.sv
// handshake channels of the tokenizer: character items in, token items out
interface slt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_stream;

	modport source (output valid, output char_code, output end_of_stream, input ready);
	modport sink (input valid, input char_code, input end_of_stream, output ready);
endinterface

interface slt_token_if;
	logic       valid;
	logic       ready;
	logic [3:0] token_kind;
	logic [7:0] token_char;
	logic [7:0] word_length;
	logic       last_result;

	modport source (
		output valid, output token_kind, output token_char, output word_length,
		output last_result, input ready
	);
	modport sink (
		input valid, input token_kind, input token_char, input word_length,
		input last_result, output ready
	);
endinterface

>>> rtl/core/slt_scan.sv
// scanner step: next word state and up to two token items for one character
module slt_scan #(
	parameter int unsigned MaxWordLength = slt_pkg::MAX_WORD_LENGTH,
	parameter int unsigned CountWidth    = $clog2(MaxWordLength + 1)
) (
	input  logic [7:0]              char_code,
	input  logic                    end_of_stream,
	input  slt_pkg::word_mode_t     mode,
	input  logic [CountWidth-1:0]   count,
	input  logic                    kw_ok,
	output slt_pkg::word_mode_t     mode_next,
	output logic [CountWidth-1:0]   count_next,
	output logic                    kw_ok_next,
	output logic                    any_result,
	output logic                    two_results,
	output slt_pkg::token_t         first,
	output slt_pkg::token_t         second
);

	localparam logic [CountWidth-1:0] CountMax = CountWidth'(MaxWordLength);
	localparam logic [CountWidth-1:0] KwLen    = CountWidth'(slt_pkg::KEYWORD_LENGTH);
	localparam logic [CountWidth-1:0] LenSat   = CountWidth'(255);

	logic                  letter;
	logic                  digit;
	logic                  space;
	logic                  in_word;
	logic                  continues;
	logic                  has_close;
	logic                  has_primary;
	logic [CountWidth-1:0] base_count;
	logic                  base_kw;
	logic                  add_kw;
	logic [CountWidth-1:0] add_count;
	slt_pkg::token_t       close_tok;
	slt_pkg::token_t       prim_tok;

	assign letter  = slt_pkg::is_letter(char_code);
	assign digit   = slt_pkg::is_digit(char_code);
	assign space   = slt_pkg::is_space(char_code);
	assign in_word = (mode == slt_pkg::MODE_WORD) || (mode == slt_pkg::MODE_INT);
	assign continues = !end_of_stream &&
		(((mode == slt_pkg::MODE_WORD) && (letter || digit)) ||
		 ((mode == slt_pkg::MODE_INT) && digit));

	// add one character onto either the running word or a fresh one
	assign base_count = continues ? count : '0;
	assign base_kw    = continues ? kw_ok : 1'b1;
	assign add_kw     = base_kw && (base_count < KwLen) &&
		(char_code == slt_pkg::keyword_char(base_count[2:0]));
	assign add_count  = (base_count < CountMax) ? base_count + 1'b1 : base_count;

	always_comb begin
		close_tok.ch   = 8'h00;
		close_tok.len  = (count > LenSat) ? 8'hff : 8'(count);
		close_tok.last = 1'b0;
		if (mode == slt_pkg::MODE_INT) begin
			close_tok.kind = slt_pkg::KIND_INTEGER;
		end else if (kw_ok && count == KwLen) begin
			close_tok.kind = slt_pkg::KIND_LOCAL;
		end else begin
			close_tok.kind = slt_pkg::KIND_IDENT;
		end
	end

	always_comb begin
		has_close   = 1'b0;
		has_primary = 1'b1;
		prim_tok    = '{kind: slt_pkg::KIND_TEXT, ch: char_code, len: 8'h00, last: 1'b1};
		mode_next   = slt_pkg::MODE_NONE;
		count_next  = '0;
		kw_ok_next  = 1'b1;
		if (end_of_stream) begin
			has_close     = in_word;
			prim_tok.kind = slt_pkg::KIND_EOF;
			prim_tok.ch   = 8'h00;
		end else if (continues) begin
			mode_next  = mode;
			count_next = add_count;
			kw_ok_next = add_kw;
		end else begin
			has_close = in_word;
			if (space) begin
				has_primary = 1'b0;
			end else if (letter || digit) begin
				mode_next  = letter ? slt_pkg::MODE_WORD : slt_pkg::MODE_INT;
				count_next = add_count;
				kw_ok_next = add_kw;
			end else begin
				prim_tok.ch = 8'h00;
				priority if (char_code == slt_pkg::CHAR_EQUALS) begin
					prim_tok.kind = slt_pkg::KIND_EQUALS;
				end else if (char_code == slt_pkg::CHAR_PLUS) begin
					prim_tok.kind = slt_pkg::KIND_PLUS;
				end else if (char_code == slt_pkg::CHAR_MINUS) begin
					prim_tok.kind = slt_pkg::KIND_MINUS;
				end else if (char_code == slt_pkg::CHAR_LPAREN) begin
					prim_tok.kind = slt_pkg::KIND_LPAREN;
				end else if (char_code == slt_pkg::CHAR_RPAREN) begin
					prim_tok.kind = slt_pkg::KIND_RPAREN;
				end else begin
					prim_tok.kind = slt_pkg::KIND_ILLEGAL;
					prim_tok.ch   = char_code;
				end
			end
		end
	end

	always_comb begin
		any_result  = has_close || has_primary;
		two_results = has_close && has_primary;
		second      = prim_tok;
		if (has_close) begin
			first      = close_tok;
			first.last = !has_primary;
		end else begin
			first = prim_tok;
		end
	end

endmodule

>>> rtl/core/small_language_tokenizer_unit.sv
// small language tokenizer: one character item in, zero to two token items out
//
// chars channel: one item per character byte (char_code), or an end_of_stream
// item that closes any pending word and yields an eof token.
// tokens channel: token_kind, token_char, word_length and last_result, which
// marks the final token caused by one character item.
// the first token item of a character is presented the cycle after it is taken.
// throughput: one character per cycle while the receiver is ready; a character
// that both closes a word and yields a token of its own gives two items, and
// the second item holds the chars channel until the first item is taken.
// the token output register and a second-item holding register decouple the
// two sides: a new character is taken while the last token is being taken.
// when the receiver stalls, the current token holds and chars.ready drops
// while a token waits in the output register; nothing is lost or repeated.
// reset clears the word state (no word, count zero, keyword match armed) and
// empties the output registers.
module small_language_tokenizer_unit #(
	parameter int unsigned MaxWordLength = slt_pkg::MAX_WORD_LENGTH
) (
	input  logic               clk,
	input  logic               arst_n,
	slt_char_if.sink           chars,
	slt_token_if.source        tokens
);

	localparam int unsigned CountWidth = $clog2(MaxWordLength + 1);

	slt_pkg::word_mode_t   mode_q;
	logic [CountWidth-1:0] count_q;
	logic                  kw_ok_q;
	logic                  out_valid_q;
	logic                  pend_valid_q;
	slt_pkg::token_t       out_q;
	slt_pkg::token_t       pend_q;

	slt_pkg::word_mode_t   mode_next;
	logic [CountWidth-1:0] count_next;
	logic                  kw_ok_next;
	logic                  any_result;
	logic                  two_results;
	slt_pkg::token_t       first;
	slt_pkg::token_t       second;
	logic                  take_in;
	logic                  take_out;

	slt_scan #(
		.MaxWordLength(MaxWordLength),
		.CountWidth   (CountWidth)
	) u_scan (
		.char_code    (chars.char_code),
		.end_of_stream(chars.end_of_stream),
		.mode         (mode_q),
		.count        (count_q),
		.kw_ok        (kw_ok_q),
		.mode_next    (mode_next),
		.count_next   (count_next),
		.kw_ok_next   (kw_ok_next),
		.any_result   (any_result),
		.two_results  (two_results),
		.first        (first),
		.second       (second)
	);

	assign take_out    = out_valid_q && tokens.ready;
	assign chars.ready = !pend_valid_q && (!out_valid_q || tokens.ready);
	assign take_in     = chars.valid && chars.ready;

	assign tokens.valid       = out_valid_q;
	assign tokens.token_kind  = out_q.kind;
	assign tokens.token_char  = out_q.ch;
	assign tokens.word_length = out_q.len;
	assign tokens.last_result = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= slt_pkg::MODE_NONE;
			count_q      <= '0;
			kw_ok_q      <= 1'b1;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (take_in) begin
				mode_q       <= mode_next;
				count_q      <= count_next;
				kw_ok_q      <= kw_ok_next;
				out_valid_q  <= any_result;
				pend_valid_q <= two_results;
			end else if (take_out) begin
				out_valid_q  <= pend_valid_q;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			out_q  <= first;
			pend_q <= second;
		end else if (take_out && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

endmodule
